FILE: sv/linked_free_list_slot_pool_unit_macros.svh
// Assertion helpers for the slot pool checker.
// Each expects clk and rst in the scope where it is used.
`ifndef LINKED_FREE_LIST_SLOT_POOL_UNIT_MACROS_SVH
`define LINKED_FREE_LIST_SLOT_POOL_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define LFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define LFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define LFL_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lfl_pkg.sv
package lfl_pkg;

  localparam int POOL_SIZE   = 32;
  localparam int SLOT_W      = $clog2(POOL_SIZE);
  localparam int PTR_W       = $clog2(POOL_SIZE + 1);
  localparam int CNT_W       = SLOT_W;
  localparam int SLOT_NUM_W  = 5;
  localparam int GRANT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - GRANT_W - STATUS_W;

  localparam logic [PTR_W-1:0] NULL_LINK = PTR_W'(POOL_SIZE);

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_ACTIVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_FIX,
    S_RESP
  } state_t;

  function automatic logic is_slot(input logic [PTR_W-1:0] v);
    return v < PTR_W'(POOL_SIZE);
  endfunction

endpackage

FILE: sv/linked_free_list_slot_pool_unit.sv
// Slot pool: hands out and takes back numbered slots from a fixed pool.
// Input channel s_*: s_tuser[0] selects allocate (0) or release (1);
// s_tdata[4:0] is the slot to release, ignored on allocate.
// Output channel m_*: one transfer per input, m_tdata[1:0] status
// (ok, pool empty, slot not active), m_tdata[6:2] granted slot.
// Both lists live in one link memory with a registered read.
// Allocate passes through S_ALLOC to S_RESP, or goes straight to S_RESP
// when the pool is empty; release walks the active list from its head
// until it finds the slot, then unlinks it in S_FIX, or gives up when the
// walk has run the whole list, and goes straight to S_RESP when the active
// list is empty. One item is in work at a time: s_tready is high only while
// idle, and each step of the release walk is one read of the link memory.
// Reset puts every slot on the free list in ascending order and empties the
// active list at once; per-entry valid bits stand in for the initial links.
// A result that m_tready does not take holds in the output register; the
// block then accepts the next item and stops before its result until the
// register is free.
module linked_free_list_slot_pool_unit import lfl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [4:0] slot_number, [7:5] zero
  input  logic [0:0]             s_tuser,   // [0] action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] status, [6:2] granted_slot, [7] zero
);

  state_t state, state_next;

  logic [PTR_W-1:0] free_head, free_head_next;
  logic [PTR_W-1:0] active_head, active_head_next;
  logic [PTR_W-1:0] target, target_next;
  logic [PTR_W-1:0] cur, cur_next;
  logic [PTR_W-1:0] prev, prev_next;
  logic [PTR_W-1:0] link_hold, link_hold_next;
  logic [CNT_W-1:0] steps, steps_next;
  status_t          res_status, res_status_next;
  logic [GRANT_W-1:0] res_granted, res_granted_next;
  logic             m_tvalid_next;
  logic [OUT_TDATA_W-1:0] m_tdata_next;

  logic [PTR_W-1:0]     link_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] link_vld;
  logic [SLOT_W-1:0]    rd_addr, rd_addr_q;
  logic [PTR_W-1:0]     rd_data;
  logic                 rd_vld;
  logic                 we;
  logic [SLOT_W-1:0]    wr_addr;
  logic [PTR_W-1:0]     wr_data;

  logic [PTR_W-1:0] raw_link;
  logic [PTR_W-1:0] nxt;
  logic             in_release;
  logic             in_slot_ok;
  logic             out_free;
  logic             walk_hit;
  logic             walk_end;

  always_ff @(posedge clk) begin
    if (we) begin
      link_mem[wr_addr] <= wr_data;
    end
    rd_data   <= link_mem[rd_addr];
    rd_vld    <= link_vld[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (we) begin
      link_vld[wr_addr] <= 1'b1;
    end
  end

  assign raw_link   = rd_vld ? rd_data : (PTR_W'(rd_addr_q) + PTR_W'(1));
  assign nxt        = is_slot(raw_link) ? raw_link : NULL_LINK;
  assign in_release = (s_tuser[0] == ACT_RELEASE);
  assign in_slot_ok = (32'(s_tdata[SLOT_NUM_W-1:0]) < POOL_SIZE);
  assign out_free   = !m_tvalid || m_tready;
  assign walk_hit   = (cur == target);
  assign walk_end   = (steps == CNT_W'(POOL_SIZE - 1)) || !is_slot(nxt);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_release) begin
            state_next = (in_slot_ok && is_slot(active_head)) ? S_WALK : S_RESP;
          end else begin
            state_next = is_slot(free_head) ? S_ALLOC : S_RESP;
          end
        end
      end
      S_ALLOC: state_next = S_RESP;
      S_WALK: begin
        if (walk_hit) begin
          state_next = S_FIX;
        end else if (walk_end) begin
          state_next = S_RESP;
        end
      end
      S_FIX: state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = 1'b0;
    free_head_next   = free_head;
    active_head_next = active_head;
    target_next      = target;
    cur_next         = cur;
    prev_next        = prev;
    link_hold_next   = link_hold;
    steps_next       = steps;
    res_status_next  = res_status;
    res_granted_next = res_granted;
    m_tvalid_next    = m_tvalid && !m_tready;
    m_tdata_next     = m_tdata;
    rd_addr          = cur[SLOT_W-1:0];
    we               = 1'b0;
    wr_addr          = cur[SLOT_W-1:0];
    wr_data          = free_head;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          res_granted_next = '0;
          target_next      = PTR_W'(s_tdata[SLOT_NUM_W-1:0]);
          if (in_release) begin
            res_status_next = ST_NOT_ACTIVE;
            cur_next        = active_head;
            prev_next       = NULL_LINK;
            steps_next      = '0;
            rd_addr         = active_head[SLOT_W-1:0];
          end else begin
            res_status_next = ST_EMPTY;
            rd_addr         = free_head[SLOT_W-1:0];
          end
        end
      end
      S_ALLOC: begin
        we               = 1'b1;
        wr_addr          = free_head[SLOT_W-1:0];
        wr_data          = active_head;
        active_head_next = free_head;
        free_head_next   = nxt;
        res_status_next  = ST_OK;
        res_granted_next = GRANT_W'(free_head);
      end
      S_WALK: begin
        rd_addr = nxt[SLOT_W-1:0];
        if (walk_hit) begin
          we             = 1'b1;
          wr_addr        = cur[SLOT_W-1:0];
          wr_data        = free_head;
          free_head_next = cur;
          link_hold_next = nxt;
        end else begin
          prev_next  = cur;
          cur_next   = nxt;
          steps_next = steps + CNT_W'(1);
        end
      end
      S_FIX: begin
        res_status_next = ST_OK;
        if (is_slot(prev)) begin
          we      = 1'b1;
          wr_addr = prev[SLOT_W-1:0];
          wr_data = link_hold;
        end else begin
          active_head_next = link_hold;
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {OUT_PAD_W'(0), res_granted, res_status};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= '0;
      active_head <= NULL_LINK;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      active_head <= active_head_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    target      <= target_next;
    cur         <= cur_next;
    prev        <= prev_next;
    link_hold   <= link_hold_next;
    steps       <= steps_next;
    res_status  <= res_status_next;
    res_granted <= res_granted_next;
    m_tdata     <= m_tdata_next;
  end

endmodule

FILE: sv/lfl_check.sv
`include "linked_free_list_slot_pool_unit_macros.svh"

module lfl_check import lfl_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [0:0]             s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  `LFL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `LFL_ASSERT_NOW(a_status_code, m_tvalid, (m_tdata[STATUS_W-1:0] == ST_OK) || (m_tdata[STATUS_W-1:0] == ST_EMPTY) || (m_tdata[STATUS_W-1:0] == ST_NOT_ACTIVE), "undefined status code")
  `LFL_ASSERT_NOW(a_grant_zero, m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK), m_tdata[STATUS_W+GRANT_W-1:STATUS_W] == '0, "granted slot set on a failed transfer")
  `LFL_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "second item accepted while one is in work")
  `LFL_ASSERT_NEXT_ALWAYS(a_reset_out, rst, !m_tvalid, "result shown right after reset")

endmodule

bind linked_free_list_slot_pool_unit lfl_check u_lfl_check (.*);

FILE: bench/linked_free_list_slot_pool_unit_test.sv
module linked_free_list_slot_pool_unit_test;
  import lfl_pkg::*;

  localparam int RANDOM_ITEMS  = 550;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = POOL_SIZE + 16;
  localparam int BACKUP_AT     = 120;
  localparam int BACKUP_CYCLES = 300;

  typedef struct packed {
    action_t                 act;
    logic [SLOT_NUM_W-1:0]   num;
  } pool_req_t;

  typedef struct packed {
    status_t                 status;
    logic [GRANT_W-1:0]      grant;
  } pool_reply_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  pool_req_t   request_queue[$];
  pool_reply_t awaited_replies[$];

  logic [PTR_W-1:0] next_slot [POOL_SIZE];
  logic [PTR_W-1:0] active_top;
  logic [PTR_W-1:0] free_top;

  int mismatch_count = 0;
  int replies_seen   = 0;
  int tx_gap         = 0;
  int tx_calm        = 0;
  int rx_hold        = 0;
  int rx_calm        = 0;
  int cycle_count    = 0;

  linked_free_list_slot_pool_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 68) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PTR_W-1:0] successor(input logic [PTR_W-1:0] s);
    if (s >= POOL_SIZE) return NULL_LINK;
    if (next_slot[s] >= POOL_SIZE) return NULL_LINK;
    return next_slot[s];
  endfunction

  task automatic apply_pool_request(input action_t act, input logic [SLOT_NUM_W-1:0] num);
    pool_reply_t      r;
    logic [PTR_W-1:0] prev;
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] target;
    bit               found;
    r.status = ST_OK;
    r.grant  = '0;
    target   = PTR_W'(num);
    if (act == ACT_ALLOC) begin
      if (free_top >= POOL_SIZE) begin
        r.status = ST_EMPTY;
      end else begin
        cur             = free_top;
        free_top        = successor(cur);
        next_slot[cur]  = active_top;
        active_top      = cur;
        r.grant         = cur[GRANT_W-1:0];
      end
    end else begin
      found = 1'b0;
      prev  = NULL_LINK;
      cur   = (active_top < POOL_SIZE) ? active_top : NULL_LINK;
      if (target < POOL_SIZE) begin
        for (int steps = 0; steps < POOL_SIZE && cur < POOL_SIZE && !found; steps++) begin
          if (cur == target) begin
            // unlink, then push onto the free list
            if (prev < POOL_SIZE) next_slot[prev] = successor(cur);
            else active_top = successor(cur);
            next_slot[cur] = free_top;
            free_top       = cur;
            found          = 1'b1;
          end else begin
            prev = cur;
            cur  = successor(cur);
          end
        end
      end
      if (!found) r.status = ST_NOT_ACTIVE;
    end
    awaited_replies.push_back(r);
  endtask

  task automatic queue_req(input action_t act, input logic [SLOT_NUM_W-1:0] num);
    pool_req_t q;
    q.act = act;
    q.num = num;
    request_queue.push_back(q);
  endtask

  always @(posedge clk) begin : driver
    pool_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        apply_pool_request(action_t'(s_tuser[0]), s_tdata[SLOT_NUM_W-1:0]);
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          req = request_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TDATA_W'(req.num);
          s_tuser  <= req.act;
          tx_gap   = idle_len(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pool_reply_t        want;
    status_t            got_status;
    logic [GRANT_W-1:0] got_grant;
    int                 stall;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_status = status_t'(m_tdata[STATUS_W-1:0]);
        got_grant  = m_tdata[STATUS_W +: GRANT_W];
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          $error("unexpected transfer: status %0d granted_slot %0d", got_status, got_grant);
          mismatch_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            mismatch_count++;
          end
          if (got_grant !== want.grant) begin
            $error("granted_slot: expected %0d, actual %0d", want.grant, got_grant);
            mismatch_count++;
          end
        end
        // back up the output so the block stalls its input
        if (replies_seen == BACKUP_AT) rx_hold = BACKUP_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        stall = idle_len(rx_calm);
        m_tready <= (stall == 0);
        rx_hold = (stall > 0) ? stall - 1 : 0;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int span;
    int alloc_pct;
    int made;
    int phase;
    int total_items;
    for (int i = 0; i < POOL_SIZE; i++)
      next_slot[i] = (i + 1 < POOL_SIZE) ? PTR_W'(i + 1) : NULL_LINK;
    active_top = NULL_LINK;
    free_top   = '0;

    // empty active list, then build 4,3,2,1,0 and take it apart
    queue_req(ACT_RELEASE, SLOT_NUM_W'(0));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(31));
    repeat (5) queue_req(ACT_ALLOC, SLOT_NUM_W'(31));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(2));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(4));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(0));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(0));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(31));
    queue_req(ACT_ALLOC, SLOT_NUM_W'(0));
    queue_req(ACT_ALLOC, SLOT_NUM_W'(21));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(5));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(1));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(3));
    queue_req(ACT_RELEASE, SLOT_NUM_W'(2));

    made  = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      kind      = (phase == 0) ? 0 : $urandom_range(0, 2);
      span      = (phase == 0) ? 60 : $urandom_range(20, 60);
      alloc_pct = (kind == 0) ? 90 : (kind == 1) ? 15 : 50;
      repeat (span) begin
        if ($urandom_range(0, 99) < alloc_pct)
          queue_req(ACT_ALLOC, SLOT_NUM_W'($urandom_range(0, (1 << SLOT_NUM_W) - 1)));
        else
          queue_req(ACT_RELEASE, SLOT_NUM_W'($urandom_range(0, (1 << SLOT_NUM_W) - 1)));
        made++;
      end
      phase++;
    end
    total_items = request_queue.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (replies_seen < total_items) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_replies.size() == 0 &&
        replies_seen == total_items) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
